// ===== hw/rtl/hspd_pkg.sv =====
// ----------------------------------------------------------------------------
// hspd_pkg
// Shared types and constants for the single-wire humidity sensor decoder.
// ----------------------------------------------------------------------------
package hspd_pkg;

  localparam int PULSE_W = 10;
  localparam int FRAME_W = 40;
  localparam int CNT_W   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [PULSE_W-1:0] RESP_LOW_MIN  = 10'd75;
  localparam logic [PULSE_W-1:0] RESP_LOW_MAX  = 10'd85;
  localparam logic [PULSE_W-1:0] RESP_HIGH_MIN = 10'd75;
  localparam logic [PULSE_W-1:0] RESP_HIGH_MAX = 10'd85;

  localparam logic [CNT_W-1:0] FRAME_BITS = 6'd40;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_LOW_MIN   = 3'd0,
    CFG_BIT_LOW_MAX   = 3'd1,
    CFG_ZERO_HIGH_MIN = 3'd2,
    CFG_ZERO_HIGH_MAX = 3'd3,
    CFG_ONE_HIGH_MIN  = 3'd4,
    CFG_ONE_HIGH_MAX  = 3'd5,
    CFG_TIMEOUT_US    = 3'd6
  } cfg_idx_t;

  // input command codes
  localparam logic CMD_ARM   = 1'b0;
  localparam logic CMD_PULSE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_COMM   = 2'd1,
    ST_NOCONN = 2'd2,
    ST_CSUM   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RESP_LOW  = 3'd1,
    PH_RESP_HIGH = 3'd2,
    PH_BIT_LOW   = 3'd3,
    PH_BIT_HIGH  = 3'd4
  } phase_t;

  // classified pulse, passed from front to back
  typedef struct packed {
    logic arm;
    logic timed_out;
    logic resp_low_ok;
    logic resp_high_ok;
    logic bit_low_ok;
    logic is_zero;
    logic is_one;
  } pulse_class_t;

endpackage

// ===== hw/rtl/hspd_front.sv =====
// ----------------------------------------------------------------------------
// hspd_front
// Holds the timing registers and classifies each incoming pulse against
// every window at once, independent of the frame phase.
// ----------------------------------------------------------------------------
module hspd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hspd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [hspd_pkg::PULSE_W-1:0]    cfg_data,
  input  logic                            command,
  input  logic [hspd_pkg::PULSE_W-1:0]    pulse_us,
  output hspd_pkg::pulse_class_t          pclass
);
  import hspd_pkg::*;

  logic [PULSE_W-1:0] bit_low_min;
  logic [PULSE_W-1:0] bit_low_max;
  logic [PULSE_W-1:0] zero_high_min;
  logic [PULSE_W-1:0] zero_high_max;
  logic [PULSE_W-1:0] one_high_min;
  logic [PULSE_W-1:0] one_high_max;
  logic [PULSE_W-1:0] timeout_us;
  logic               timed_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_low_min   <= 10'd40;
      bit_low_max   <= 10'd60;
      zero_high_min <= 10'd15;
      zero_high_max <= 10'd35;
      one_high_min  <= 10'd60;
      one_high_max  <= 10'd80;
      timeout_us    <= 10'd200;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BIT_LOW_MIN:   bit_low_min   <= cfg_data;
        CFG_BIT_LOW_MAX:   bit_low_max   <= cfg_data;
        CFG_ZERO_HIGH_MIN: zero_high_min <= cfg_data;
        CFG_ZERO_HIGH_MAX: zero_high_max <= cfg_data;
        CFG_ONE_HIGH_MIN:  one_high_min  <= cfg_data;
        CFG_ONE_HIGH_MAX:  one_high_max  <= cfg_data;
        CFG_TIMEOUT_US:    timeout_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign timed_out = (pulse_us >= timeout_us);

  always_comb begin
    pclass.arm          = (command == CMD_ARM);
    pclass.timed_out    = timed_out;
    pclass.resp_low_ok  = !timed_out && pulse_us >= RESP_LOW_MIN && pulse_us <= RESP_LOW_MAX;
    pclass.resp_high_ok = !timed_out && pulse_us >= RESP_HIGH_MIN &&
                          pulse_us <= RESP_HIGH_MAX;
    pclass.bit_low_ok   = !timed_out && pulse_us >= bit_low_min && pulse_us <= bit_low_max;
    // strict windows for the high pulse
    pclass.is_zero      = pulse_us > zero_high_min && pulse_us < zero_high_max;
    pclass.is_one       = pulse_us > one_high_min && pulse_us < one_high_max;
  end

endmodule

// ===== hw/rtl/hspd_queue.sv =====
// ----------------------------------------------------------------------------
// hspd_queue
// Short first-in first-out buffer of classified pulses between the front
// and the back.
// ----------------------------------------------------------------------------
module hspd_queue #(
  parameter int DEPTH = hspd_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hspd_pkg::pulse_class_t in_data,
  output logic                   out_valid,
  input  logic                   out_pop,
  output hspd_pkg::pulse_class_t out_data
);
  import hspd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pulse_class_t    mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hspd_back.sv =====
// ----------------------------------------------------------------------------
// hspd_back
// Frame sequencer: walks the response and data-bit phases, shifts the bits
// in, checks the byte sum and holds the result in an output register.
// ----------------------------------------------------------------------------
module hspd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  hspd_pkg::pulse_class_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hspd_pkg::status_t      out_status,
  output logic [15:0]            out_humidity,
  output logic [15:0]            out_temperature
);
  import hspd_pkg::*;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     bits_left, bits_left_next;
  logic [FRAME_W-1:0]   frame_shift, frame_shift_next;
  logic [FRAME_W-1:0]   frame_full;
  logic [7:0]           byte_sum;
  logic                 emit;
  status_t              emit_status;
  logic                 emit_data;

  // a new pulse is taken whenever the output register is free or draining
  assign q_pop      = q_valid && (!out_valid || out_ready);
  assign frame_full = {frame_shift[FRAME_W-2:0], q_data.is_one && !q_data.is_zero};
  assign byte_sum   = frame_full[39:32] + frame_full[31:24] + frame_full[23:16] +
                      frame_full[15:8];

  always_comb begin
    phase_next       = phase;
    bits_left_next   = bits_left;
    frame_shift_next = frame_shift;
    emit             = 1'b0;
    emit_status      = ST_COMM;
    emit_data        = 1'b0;
    if (q_pop) begin
      if (q_data.arm) begin
        phase_next       = PH_RESP_LOW;
        bits_left_next   = FRAME_BITS;
        frame_shift_next = '0;
      end else begin
        unique case (phase)
          PH_IDLE: ;
          PH_RESP_LOW: begin
            if (q_data.resp_low_ok) begin
              phase_next = PH_RESP_HIGH;
            end else begin
              emit       = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_RESP_HIGH: begin
            if (q_data.resp_high_ok) begin
              phase_next = PH_BIT_LOW;
            end else begin
              emit       = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_BIT_LOW: begin
            if (q_data.bit_low_ok) begin
              phase_next = PH_BIT_HIGH;
            end else begin
              emit       = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_BIT_HIGH: begin
            if (q_data.timed_out) begin
              emit        = 1'b1;
              emit_status = ST_NOCONN;
              phase_next  = PH_IDLE;
            end else if (!q_data.is_zero && !q_data.is_one) begin
              emit       = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              frame_shift_next = frame_full;
              bits_left_next   = bits_left - 1'b1;
              if (bits_left_next == '0) begin
                emit        = 1'b1;
                emit_data   = 1'b1;
                emit_status = (byte_sum == frame_full[7:0]) ? ST_OK : ST_CSUM;
                phase_next  = PH_IDLE;
              end else begin
                phase_next = PH_BIT_LOW;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bits_left   <= '0;
      frame_shift <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      bits_left   <= bits_left_next;
      frame_shift <= frame_shift_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status      <= emit_status;
      out_humidity    <= emit_data ? frame_full[39:24] : 16'd0;
      out_temperature <= emit_data ? frame_full[23:8] : 16'd0;
    end
  end

endmodule

// ===== hw/rtl/humidity_sensor_pulse_decoder_top.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_pulse_decoder_top
// Single-wire humidity sensor frame receiver driven by measured pulse widths.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: command, tdata: pulse_us
//   m_*      out  m_tvalid/m_tready  tuser: status, tdata: humidity, temperature
//   cfg_*    in   cfg_we             cfg_addr register index, cfg_data value
//
// one pulse per cycle sustained unless the output stalls; a pulse passes the queue
// memory on its way to the back, and each result is held in the output register.
// the pulse queue absorbs output stalls; s_tready drops only when it is full.
// reset is synchronous, clears state and queue, and restores the timing defaults.
// ----------------------------------------------------------------------------
module humidity_sensor_pulse_decoder_top #(
  parameter int QUEUE_DEPTH = hspd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [9:0] pulse_us
  input  logic                           s_tuser,   // [0] command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // [15:0] humidity, [31:16] temperature
  output logic [1:0]                     m_tuser,   // [1:0] status
  input  logic                           cfg_we,
  input  logic [hspd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [hspd_pkg::PULSE_W-1:0]   cfg_data
);
  import hspd_pkg::*;

  pulse_class_t pclass;
  pulse_class_t q_data;
  logic         q_valid;
  logic         q_pop;
  status_t      out_status;
  logic [15:0]  out_humidity;
  logic [15:0]  out_temperature;

  hspd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .command  (s_tuser),
    .pulse_us (s_tdata[PULSE_W-1:0]),
    .pclass   (pclass)
  );

  hspd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (pclass),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  hspd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (out_status),
    .out_humidity    (out_humidity),
    .out_temperature (out_temperature)
  );

  assign m_tuser = out_status;
  assign m_tdata = {out_temperature, out_humidity};

  // communication and no-connection results never carry frame data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_COMM || m_tuser == ST_NOCONN) |-> m_tdata == 32'd0)
    else $error("error result with nonzero payload");

  // arming never produces a result
  a_arm_silent: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_data.arm |=> !m_tvalid)
    else $error("result after arm command");

  // input backpressure only when the queue holds pulses
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule
